FILE: rtl/core/first_fit_chunk_allocator_defines.svh
// Assertion helpers for the checker file of the chunk allocator.
`ifndef FIRST_FIT_CHUNK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_CHUNK_ALLOCATOR_DEFINES_SVH

// Property checked on every rising edge of clk, switched off while rst_n is low.
`define FFCA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising edge of clk, reset cycles included.
`define FFCA_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/ffca_pkg.sv
package ffca_pkg;

  // Defaults of the top level parameters.
  localparam int MAX_CHUNKS_DEF  = 1024;
  localparam int CHUNK_BYTES_DEF = 64;
  localparam int TAG_COUNT_DEF   = 16;

  // Fixed field widths.
  localparam int REQ_W   = 2;
  localparam int SIZE_W  = 17;
  localparam int TAG_W   = 4;
  localparam int OFFS_W  = 16;
  localparam int STAT_W  = 2;
  localparam int TOT_W   = 17;
  localparam int CNT_W   = 11;
  localparam int ARENA_W = 11;

  localparam logic [ARENA_W-1:0] ARENA_RST = 11'd1024;

  // Request codes.
  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC       = 2'd0,
    REQ_RELEASE     = 2'd1,
    REQ_RELEASE_TAG = 2'd2,
    REQ_QUERY       = 2'd3
  } req_t;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_DONE      = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_IGNORED   = 2'd2
  } status_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_DEC,
    S_A_RD,
    S_A_CHK,
    S_MARK,
    S_R_RD,
    S_R_CHK,
    S_FREE,
    S_S_RD,
    S_S_CHK,
    S_FIN
  } state_t;

endpackage

FILE: rtl/core/ffca_if.sv
// Request channel.
interface ffca_req_if;
  import ffca_pkg::*;
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [SIZE_W-1:0] size_bytes;
  logic [TAG_W-1:0]  tag;
  logic [OFFS_W-1:0] block_offset;
  modport source (output valid, req_type, size_bytes, tag, block_offset, input ready);
  modport sink (input valid, req_type, size_bytes, tag, block_offset, output ready);
endinterface

// Result channel.
interface ffca_rsp_if;
  import ffca_pkg::*;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [OFFS_W-1:0] granted_offset;
  logic [TOT_W-1:0]  total_bytes;
  logic [CNT_W-1:0]  live_blocks;
  logic [TOT_W-1:0]  tag_bytes;
  logic [CNT_W-1:0]  tag_blocks;
  modport source (output valid, status, granted_offset, total_bytes, live_blocks,
                  tag_bytes, tag_blocks, input ready);
  modport sink (input valid, status, granted_offset, total_bytes, live_blocks,
                tag_bytes, tag_blocks, output ready);
endinterface

// Arena size write channel.
interface ffca_cfg_if;
  import ffca_pkg::*;
  logic               valid;
  logic               ready;
  logic [ARENA_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

FILE: rtl/core/ffca_ram.sv
module ffca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/first_fit_chunk_allocator.sv
// First-fit chunk allocator.
// in_req carries one request per beat: allocate, release, release all of a
// tag, or query. out_rsp returns one result beat per request with the status,
// the granted offset and the live totals. cfg_wr writes the arena size in
// chunks and is always ready; the user must write it only while no request is
// open, and the block itself does not enforce this. The chunk map (in-use and
// block-start bits) and the block records sit in two RAMs, each with one write
// port and one registered read port; a scan reads one chunk and then checks it.
// The chunk size is a power of two, so bytes and offsets map to chunks by a shift.
// An allocate scans the usable chunks and marks the granted ones; a release frees
// the chunks of its block; a release all of a tag scans the whole map and frees
// each block of that tag. A query, and a request refused at decode, goes straight
// to the result. One request is open at a time; the next is accepted from the
// cycle in which the result is first offered. After reset the block clears the
// chunk map with in_req not ready; totals and per-tag counts clear at once.
// When out_rsp is stalled the result holds in the output register; the block
// takes the next request and stops at its end until the register frees.
module first_fit_chunk_allocator #(
  parameter int MAX_CHUNKS  = ffca_pkg::MAX_CHUNKS_DEF,
  parameter int CHUNK_BYTES = ffca_pkg::CHUNK_BYTES_DEF,
  parameter int TAG_COUNT   = ffca_pkg::TAG_COUNT_DEF
) (
  input logic        clk,
  input logic        rst_n,
  ffca_req_if.sink   in_req,
  ffca_rsp_if.source out_rsp,
  ffca_cfg_if.sink   cfg_wr
);
  import ffca_pkg::*;

  localparam int CW   = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int UW   = CW + 1;
  localparam int XW   = (UW > ARENA_W) ? UW : ARENA_W;
  localparam int TW   = (TAG_COUNT > 1) ? $clog2(TAG_COUNT) : 1;
  localparam int QW   = SIZE_W + 1;
  localparam int SHW  = $clog2(CHUNK_BYTES);
  localparam int RECW = TW + SIZE_W + UW;

  // Folds the input tag into the range of tag slots.
  function automatic logic [TW-1:0] fold_tag(input logic [TAG_W-1:0] t);
    int v;
    v = int'(t);
    for (int i = 0; i < (1 << TAG_W); i++) begin
      if (v >= TAG_COUNT) begin
        v = v - TAG_COUNT;
      end
    end
    return TW'(v);
  endfunction

  state_t state_r, state_nxt;

  logic [ARENA_W-1:0] arena_r;
  req_t               req_r, req_nxt;
  logic [SIZE_W-1:0]  size_r, size_nxt;
  logic [TW-1:0]      tag_r, tag_nxt;
  logic [UW-1:0]      ptr_r, ptr_nxt;
  logic [UW-1:0]      run_r, run_nxt;
  logic [UW-1:0]      need_r, need_nxt;
  logic [UW-1:0]      cnt_r, cnt_nxt;
  logic [UW-1:0]      wptr_r, wptr_nxt;
  logic [CW-1:0]      found_r, found_nxt;
  logic [QW-1:0]      dx_r, dx_nxt;
  status_t            status_r, status_nxt;
  logic [OFFS_W-1:0]  granted_r, granted_nxt;

  logic [TOT_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] live_r, live_nxt;
  logic [TOT_W-1:0] ptb_r [TAG_COUNT];
  logic [TOT_W-1:0] ptb_nxt [TAG_COUNT];
  logic [CNT_W-1:0] ptk_r [TAG_COUNT];
  logic [CNT_W-1:0] ptk_nxt [TAG_COUNT];

  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [OFFS_W-1:0] out_granted_r, out_granted_nxt;
  logic [TOT_W-1:0]  out_total_r, out_total_nxt;
  logic [CNT_W-1:0]  out_live_r, out_live_nxt;
  logic [TOT_W-1:0]  out_tbytes_r, out_tbytes_nxt;
  logic [CNT_W-1:0]  out_tblocks_r, out_tblocks_nxt;

  // Memory ports.
  logic            map_we;
  logic [CW-1:0]   map_waddr;
  logic [1:0]      map_wdata;
  logic [1:0]      map_q;
  logic            rec_we;
  logic [RECW-1:0] rec_wdata;
  logic [RECW-1:0] rec_q;

  // Shared decode.
  logic                in_fire;
  logic [XW-1:0]       arena_ext;
  logic [UW-1:0]       usable;
  logic [QW-1:0]       dq;
  logic [QW-1:0]       drem;
  logic [QW-1:0]       need_full;
  logic                alloc_bad;
  logic                rel_bad;
  logic                a_end;
  logic [UW-1:0]       run_inc;
  logic                a_hit;
  logic                free_last;
  logic                s_end;
  logic                s_hit;
  logic                fin_go;
  logic                clr_last;
  logic [TW-1:0]       rec_tag;
  logic [SIZE_W-1:0]   rec_bytes;
  logic [UW-1:0]       rec_count;
  logic [TW-1:0]       tsel;

  assign in_fire   = in_req.valid && in_req.ready;
  assign arena_ext = XW'(arena_r);
  assign usable    = (arena_ext > XW'(MAX_CHUNKS)) ? UW'(MAX_CHUNKS) : UW'(arena_r);

  assign rec_tag   = rec_q[RECW-1 -: TW];
  assign rec_bytes = rec_q[UW +: SIZE_W];
  assign rec_count = rec_q[UW-1:0];

  // Chunk index and byte remainder of the latched count or offset.
  assign dq   = dx_r >> SHW;
  assign drem = dx_r & QW'(CHUNK_BYTES - 1);

  assign need_full = (dq == '0) ? QW'(1) : dq;
  assign alloc_bad = need_full > QW'(usable);
  assign rel_bad   = (drem != '0) || (dq >= QW'(usable));
  assign a_end     = ptr_r >= usable;
  assign run_inc   = run_r + UW'(1);
  assign a_hit     = !map_q[1] && (run_inc >= need_r);
  assign free_last = (cnt_r == UW'(1)) || (wptr_r == UW'(MAX_CHUNKS - 1));
  assign s_end     = ptr_r == UW'(MAX_CHUNKS);
  assign s_hit     = map_q[0] && (rec_tag == tag_r);
  assign fin_go    = !out_valid_r || out_rsp.ready;
  assign clr_last  = ptr_r == UW'(MAX_CHUNKS - 1);
  assign tsel      = ((state_r == S_R_CHK) || (state_r == S_S_CHK)) ? rec_tag : tag_r;

  // Chunk map: bit 1 in use, bit 0 a block starts here.
  ffca_ram #(.WIDTH(2), .DEPTH(MAX_CHUNKS)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (ptr_r[CW-1:0]),
    .rdata (map_q)
  );

  // Block records at the first chunk: tag, requested bytes, chunk count.
  ffca_ram #(.WIDTH(RECW), .DEPTH(MAX_CHUNKS)) u_rec (
    .clk   (clk),
    .we    (rec_we),
    .waddr (found_r),
    .wdata (rec_wdata),
    .raddr (ptr_r[CW-1:0]),
    .rdata (rec_q)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:   if (clr_last) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_fire) begin
          unique case (req_t'(in_req.req_type))
            REQ_ALLOC, REQ_RELEASE: state_nxt = S_DEC;
            REQ_RELEASE_TAG:        state_nxt = S_S_RD;
            default:                state_nxt = S_FIN;
          endcase
        end
      end
      S_DEC: begin
        if (req_r == REQ_ALLOC) begin
          state_nxt = alloc_bad ? S_FIN : S_A_RD;
        end else begin
          state_nxt = rel_bad ? S_FIN : S_R_RD;
        end
      end
      S_A_RD:  state_nxt = a_end ? S_FIN : S_A_CHK;
      S_A_CHK: state_nxt = a_hit ? S_MARK : S_A_RD;
      S_MARK:  if (cnt_r == UW'(1)) state_nxt = S_FIN;
      S_R_RD:  state_nxt = S_R_CHK;
      S_R_CHK: state_nxt = map_q[0] ? S_FREE : S_FIN;
      S_FREE: begin
        if (free_last) begin
          state_nxt = (req_r == REQ_RELEASE) ? S_FIN : S_S_RD;
        end
      end
      S_S_RD:  state_nxt = s_end ? S_FIN : S_S_CHK;
      S_S_CHK: state_nxt = s_hit ? S_FREE : S_S_RD;
      S_FIN:   if (fin_go) state_nxt = S_IDLE;
      default: state_nxt = S_CLR;
    endcase
  end

  // Datapath, memory control and result register.
  always_comb begin
    req_nxt         = req_r;
    size_nxt        = size_r;
    tag_nxt         = tag_r;
    ptr_nxt         = ptr_r;
    run_nxt         = run_r;
    need_nxt        = need_r;
    cnt_nxt         = cnt_r;
    wptr_nxt        = wptr_r;
    found_nxt       = found_r;
    dx_nxt          = dx_r;
    status_nxt      = status_r;
    granted_nxt     = granted_r;
    sum_nxt         = sum_r;
    live_nxt        = live_r;
    ptb_nxt         = ptb_r;
    ptk_nxt         = ptk_r;
    out_valid_nxt   = out_valid_r && !out_rsp.ready;
    out_status_nxt  = out_status_r;
    out_granted_nxt = out_granted_r;
    out_total_nxt   = out_total_r;
    out_live_nxt    = out_live_r;
    out_tbytes_nxt  = out_tbytes_r;
    out_tblocks_nxt = out_tblocks_r;
    map_we          = 1'b0;
    map_waddr       = wptr_r[CW-1:0];
    map_wdata       = 2'b00;
    rec_we          = 1'b0;
    rec_wdata       = {tag_r, size_r, need_r};

    unique case (state_r)
      // Clearing pass over the chunk map after reset.
      S_CLR: begin
        map_we    = 1'b1;
        map_waddr = ptr_r[CW-1:0];
        ptr_nxt   = clr_last ? '0 : ptr_r + UW'(1);
      end
      S_IDLE: begin
        if (in_fire) begin
          req_nxt     = req_t'(in_req.req_type);
          size_nxt    = in_req.size_bytes;
          tag_nxt     = fold_tag(in_req.tag);
          status_nxt  = ST_DONE;
          granted_nxt = '0;
          ptr_nxt     = '0;
          run_nxt     = '0;
          if (req_t'(in_req.req_type) == REQ_ALLOC) begin
            dx_nxt = QW'(in_req.size_bytes) + QW'(CHUNK_BYTES - 1);
          end else begin
            dx_nxt = QW'(in_req.block_offset);
          end
        end
      end
      S_DEC: begin
        if (req_r == REQ_ALLOC) begin
          if (alloc_bad) begin
            status_nxt = ST_EXHAUSTED;
          end else begin
            need_nxt = UW'(need_full);
          end
        end else begin
          if (rel_bad) begin
            status_nxt = ST_IGNORED;
          end else begin
            ptr_nxt = UW'(dq);
          end
        end
      end
      S_A_RD: begin
        if (a_end) status_nxt = ST_EXHAUSTED;
      end
      // First fit: count the current run of free chunks.
      S_A_CHK: begin
        if (map_q[1]) begin
          run_nxt = '0;
          ptr_nxt = ptr_r + UW'(1);
        end else if (a_hit) begin
          found_nxt = CW'(run_inc == need_r ? ptr_r + UW'(1) - need_r : ptr_r);
          wptr_nxt  = ptr_r + UW'(1) - need_r;
          cnt_nxt   = need_r;
        end else begin
          run_nxt = run_inc;
          ptr_nxt = ptr_r + UW'(1);
        end
      end
      // Mark the granted chunks and record the block at its first chunk.
      S_MARK: begin
        map_we    = 1'b1;
        map_wdata = {1'b1, wptr_r[CW-1:0] == found_r};
        rec_we    = wptr_r[CW-1:0] == found_r;
        wptr_nxt  = wptr_r + UW'(1);
        cnt_nxt   = cnt_r - UW'(1);
        if (cnt_r == UW'(1)) begin
          sum_nxt        = sum_r + TOT_W'(size_r);
          live_nxt       = live_r + CNT_W'(1);
          ptb_nxt[tsel]  = ptb_r[tsel] + TOT_W'(size_r);
          ptk_nxt[tsel]  = ptk_r[tsel] + CNT_W'(1);
          granted_nxt    = OFFS_W'(32'(found_r) * 32'(CHUNK_BYTES));
        end
      end
      S_R_RD: begin
      end
      S_R_CHK, S_S_CHK: begin
        if ((state_r == S_R_CHK) ? map_q[0] : s_hit) begin
          sum_nxt       = sum_r - TOT_W'(rec_bytes);
          live_nxt      = live_r - CNT_W'(1);
          ptb_nxt[tsel] = ptb_r[tsel] - TOT_W'(rec_bytes);
          ptk_nxt[tsel] = ptk_r[tsel] - CNT_W'(1);
          wptr_nxt      = ptr_r;
          cnt_nxt       = rec_count;
        end else if (state_r == S_R_CHK) begin
          status_nxt = ST_IGNORED;
        end else begin
          ptr_nxt = ptr_r + UW'(1);
        end
      end
      // Free the chunks of a dropped block.
      S_FREE: begin
        map_we   = 1'b1;
        wptr_nxt = wptr_r + UW'(1);
        cnt_nxt  = cnt_r - UW'(1);
        if (free_last && req_r != REQ_RELEASE) begin
          ptr_nxt = ptr_r + UW'(1);
        end
      end
      S_S_RD: begin
        if (s_end) begin
          ptb_nxt[tsel] = '0;
          ptk_nxt[tsel] = '0;
        end
      end
      S_FIN: begin
        if (fin_go) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = status_r;
          out_granted_nxt = granted_r;
          out_total_nxt   = sum_r;
          out_live_nxt    = live_r;
          out_tbytes_nxt  = ptb_r[tsel];
          out_tblocks_nxt = ptk_r[tsel];
        end
      end
      default: begin
      end
    endcase
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      ptr_r       <= '0;
      arena_r     <= ARENA_RST;
      sum_r       <= '0;
      live_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < TAG_COUNT; i++) begin
        ptb_r[i] <= '0;
        ptk_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      sum_r       <= sum_nxt;
      live_r      <= live_nxt;
      out_valid_r <= out_valid_nxt;
      ptb_r       <= ptb_nxt;
      ptk_r       <= ptk_nxt;
      if (cfg_wr.valid) begin
        arena_r <= cfg_wr.data;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    req_r         <= req_nxt;
    size_r        <= size_nxt;
    tag_r         <= tag_nxt;
    run_r         <= run_nxt;
    need_r        <= need_nxt;
    cnt_r         <= cnt_nxt;
    wptr_r        <= wptr_nxt;
    found_r       <= found_nxt;
    dx_r          <= dx_nxt;
    status_r      <= status_nxt;
    granted_r     <= granted_nxt;
    out_status_r  <= out_status_nxt;
    out_granted_r <= out_granted_nxt;
    out_total_r   <= out_total_nxt;
    out_live_r    <= out_live_nxt;
    out_tbytes_r  <= out_tbytes_nxt;
    out_tblocks_r <= out_tblocks_nxt;
  end

  assign in_req.ready          = (state_r == S_IDLE);
  assign cfg_wr.ready          = 1'b1;
  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.status        = out_status_r;
  assign out_rsp.granted_offset = out_granted_r;
  assign out_rsp.total_bytes   = out_total_r;
  assign out_rsp.live_blocks   = out_live_r;
  assign out_rsp.tag_bytes     = out_tbytes_r;
  assign out_rsp.tag_blocks    = out_tblocks_r;

endmodule

FILE: rtl/core/ffca_checker.sv
`include "first_fit_chunk_allocator_defines.svh"

module ffca_port_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [ffca_pkg::STAT_W-1:0] out_status,
  input logic [ffca_pkg::OFFS_W-1:0] out_granted_offset,
  input logic [ffca_pkg::TOT_W-1:0]  out_total_bytes,
  input logic [ffca_pkg::CNT_W-1:0]  out_live_blocks,
  input logic [ffca_pkg::TOT_W-1:0]  out_tag_bytes,
  input logic [ffca_pkg::CNT_W-1:0]  out_tag_blocks
);
  import ffca_pkg::*;

  // The map is being cleared straight after reset, so no request is taken.
  `FFCA_ASSERT_NR(a_clear_after_reset, !rst_n |=> !in_ready, "request taken during clearing")

  // A stalled result beat stays offered.
  `FFCA_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result beat dropped")

  // Only a successful allocate reports an offset.
  `FFCA_ASSERT(a_granted_zero,
    out_valid && (out_status != ST_DONE) |-> (out_granted_offset == '0),
    "offset reported for a failed request")

  // With no live block every total must be empty.
  `FFCA_ASSERT(a_empty_totals,
    out_valid && (out_live_blocks == '0) |-> (out_total_bytes == '0) &&
    (out_tag_blocks == '0) && (out_tag_bytes == '0),
    "totals inconsistent with no live blocks")

endmodule

bind first_fit_chunk_allocator ffca_port_checker u_ffca_port_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_req.ready),
  .out_valid          (out_rsp.valid),
  .out_ready          (out_rsp.ready),
  .out_status         (out_rsp.status),
  .out_granted_offset (out_rsp.granted_offset),
  .out_total_bytes    (out_rsp.total_bytes),
  .out_live_blocks    (out_rsp.live_blocks),
  .out_tag_bytes      (out_rsp.tag_bytes),
  .out_tag_blocks     (out_rsp.tag_blocks)
);

FILE: tb/ffca_checker.sv
// Watches the request, result and arena size channels of the chunk allocator,
// keeps its own copy of the arena and the live counts, and compares every
// result beat with the oldest outstanding prediction.
module ffca_checker
  import ffca_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [REQ_W-1:0]   in_req_type,
  input  logic [SIZE_W-1:0]  in_size_bytes,
  input  logic [TAG_W-1:0]   in_tag,
  input  logic [OFFS_W-1:0]  in_block_offset,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [STAT_W-1:0]  out_status,
  input  logic [OFFS_W-1:0]  out_granted_offset,
  input  logic [TOT_W-1:0]   out_total_bytes,
  input  logic [CNT_W-1:0]   out_live_blocks,
  input  logic [TOT_W-1:0]   out_tag_bytes,
  input  logic [CNT_W-1:0]   out_tag_blocks,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [ARENA_W-1:0] cfg_data,
  output int                 fail_count,
  output int                 pending,
  output int                 grant_count,
  output int                 exhaust_count,
  output int                 ignore_count
);

  localparam int NCHUNK = MAX_CHUNKS_DEF;
  localparam int CBYTES = CHUNK_BYTES_DEF;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [OFFS_W-1:0] granted;
    logic [TOT_W-1:0]  total;
    logic [CNT_W-1:0]  live;
    logic [TOT_W-1:0]  tbytes;
    logic [CNT_W-1:0]  tblocks;
  } arena_report_t;

  arena_report_t reports_due[$];

  // Model of the arena: chunk map, block records and running totals.
  logic               chunk_busy [NCHUNK];
  logic               head_mark  [NCHUNK];
  logic [CNT_W-1:0]   head_chunks[NCHUNK];
  logic [SIZE_W-1:0]  head_bytes [NCHUNK];
  logic [TAG_W-1:0]   head_tag   [NCHUNK];
  logic [TOT_W-1:0]   live_sum;
  logic [CNT_W-1:0]   live_cnt;
  logic [TOT_W-1:0]   tag_sum[16];
  logic [CNT_W-1:0]   tag_cnt[16];
  logic [ARENA_W-1:0] arena_size;

  // Frees the block whose first chunk is c and rolls back the counts.
  function automatic void drop_block(int c);
    int t;
    t = head_tag[c];
    for (int i = 0; i < head_chunks[c] && c + i < NCHUNK; i++) chunk_busy[c + i] = 1'b0;
    head_mark[c] = 1'b0;
    live_sum -= head_bytes[c];
    live_cnt -= 1'b1;
    tag_sum[t] -= head_bytes[c];
    tag_cnt[t] -= 1'b1;
  endfunction

  // Applies one request to the model and returns the report it must produce.
  function automatic arena_report_t serve_request(req_t kind, logic [SIZE_W-1:0] size,
                                                  logic [TAG_W-1:0] tag,
                                                  logic [OFFS_W-1:0] offs);
    arena_report_t r;
    int usable, need, run, found, c;
    r = '0;
    r.status = ST_DONE;
    usable = (arena_size > NCHUNK) ? NCHUNK : arena_size;
    case (kind)
      REQ_ALLOC: begin
        need = (int'(size) + CBYTES - 1) / CBYTES;
        if (need == 0) need = 1;
        found = -1;
        run = 0;
        if (need <= usable) begin
          for (c = 0; c < usable; c++) begin
            if (chunk_busy[c]) run = 0;
            else begin
              run++;
              if (run >= need) begin
                found = c + 1 - need;
                break;
              end
            end
          end
        end
        if (found >= 0) begin
          for (c = 0; c < need; c++) chunk_busy[found + c] = 1'b1;
          head_mark[found]   = 1'b1;
          head_chunks[found] = CNT_W'(need);
          head_bytes[found]  = size;
          head_tag[found]    = tag;
          live_sum += size;
          live_cnt += 1'b1;
          tag_sum[tag] += size;
          tag_cnt[tag] += 1'b1;
          r.granted = OFFS_W'(found * CBYTES);
          grant_count++;
        end else begin
          r.status = ST_EXHAUSTED;
          exhaust_count++;
        end
      end
      REQ_RELEASE: begin
        c = offs / CBYTES;
        if (offs % CBYTES == 0 && c < usable && head_mark[c]) drop_block(c);
        else begin
          r.status = ST_IGNORED;
          ignore_count++;
        end
      end
      REQ_RELEASE_TAG: begin
        for (c = 0; c < NCHUNK; c++)
          if (head_mark[c] && head_tag[c] == tag) drop_block(c);
        tag_sum[tag] = '0;
        tag_cnt[tag] = '0;
      end
      default: ;
    endcase
    r.total   = live_sum;
    r.live    = live_cnt;
    r.tbytes  = tag_sum[tag];
    r.tblocks = tag_cnt[tag];
    return r;
  endfunction

  // Result beats are checked before the request beat of the same edge is predicted.
  always @(posedge clk) begin
    arena_report_t want;
    if (!rst_n) begin
      reports_due.delete();
      for (int i = 0; i < NCHUNK; i++) begin
        chunk_busy[i] = 1'b0;
        head_mark[i]  = 1'b0;
      end
      for (int i = 0; i < 16; i++) begin
        tag_sum[i] = '0;
        tag_cnt[i] = '0;
      end
      live_sum = '0;
      live_cnt = '0;
      arena_size = ARENA_RST;
      fail_count = 0;
      grant_count = 0;
      exhaust_count = 0;
      ignore_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (reports_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("Result beat with no request outstanding");
        end else begin
          want = reports_due.pop_front();
          if (want.status !== out_status || want.granted !== out_granted_offset ||
              want.total !== out_total_bytes || want.live !== out_live_blocks ||
              want.tbytes !== out_tag_bytes || want.tblocks !== out_tag_blocks) begin
            fail_count++;
            if (fail_count <= 10)
              $display("Mismatch: expected st=%0d off=%0d tot=%0d live=%0d tb=%0d tn=%0d, got st=%0d off=%0d tot=%0d live=%0d tb=%0d tn=%0d",
                       want.status, want.granted, want.total, want.live, want.tbytes,
                       want.tblocks, out_status, out_granted_offset, out_total_bytes,
                       out_live_blocks, out_tag_bytes, out_tag_blocks);
          end
        end
      end
      if (cfg_valid && cfg_ready) arena_size = cfg_data;
      if (in_valid && in_ready)
        reports_due.push_back(serve_request(req_t'(in_req_type), in_size_bytes, in_tag,
                                            in_block_offset));
    end
    pending = reports_due.size();
  end

endmodule

FILE: tb/tb_first_fit_chunk_allocator.sv
// Stimulus and verdict for the chunk allocator; checking is done by ffca_checker.
module tb_first_fit_chunk_allocator;
  import ffca_pkg::*;

  localparam int STALL_LIMIT = 60000;
  localparam int LONG_HOLD   = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count, pending, grant_count, exhaust_count, ignore_count;
  int   idle_cycles = 0;
  int   sent = 0;
  bit   no_gaps = 1'b0;
  bit   hold_request = 1'b0;
  logic [OFFS_W-1:0] known_offsets[$];

  ffca_req_if req_ch();
  ffca_rsp_if rsp_ch();
  ffca_cfg_if cfg_ch();

  always #2 clk = ~clk;

  first_fit_chunk_allocator uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch),
    .cfg_wr  (cfg_ch)
  );

  ffca_checker chk (
    .clk (clk), .rst_n (rst_n),
    .in_valid (req_ch.valid), .in_ready (req_ch.ready), .in_req_type (req_ch.req_type),
    .in_size_bytes (req_ch.size_bytes), .in_tag (req_ch.tag),
    .in_block_offset (req_ch.block_offset),
    .out_valid (rsp_ch.valid), .out_ready (rsp_ch.ready), .out_status (rsp_ch.status),
    .out_granted_offset (rsp_ch.granted_offset), .out_total_bytes (rsp_ch.total_bytes),
    .out_live_blocks (rsp_ch.live_blocks), .out_tag_bytes (rsp_ch.tag_bytes),
    .out_tag_blocks (rsp_ch.tag_blocks),
    .cfg_valid (cfg_ch.valid), .cfg_ready (cfg_ch.ready), .cfg_data (cfg_ch.data),
    .fail_count (fail_count), .pending (pending), .grant_count (grant_count),
    .exhaust_count (exhaust_count), .ignore_count (ignore_count)
  );

  // Watchdog: ends the run when no beat moves for too long.
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stalls, one long hold on request, and offsets kept for releases.
  initial begin
    int gap;
    rsp_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      gap = no_gaps ? 0 : $urandom_range(15);
      if (hold_request) begin
        hold_request = 1'b0;
        gap = LONG_HOLD;
      end
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      if (rsp_ch.status == ST_DONE) begin
        known_offsets.push_back(rsp_ch.granted_offset);
        if (known_offsets.size() > 64) void'(known_offsets.pop_front());
      end
    end
  end

  // Offers one request beat after a random gap and waits for its acceptance.
  task automatic send_req(req_t kind, logic [SIZE_W-1:0] size, logic [TAG_W-1:0] tag,
                          logic [OFFS_W-1:0] offs);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(15);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= kind;
    req_ch.size_bytes   <= size;
    req_ch.tag          <= tag;
    req_ch.block_offset <= offs;
    do @(posedge clk); while (!req_ch.ready);
    sent++;
  endtask

  // Waits until every outstanding result has arrived.
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Writes the arena size; only called once the block is idle.
  task automatic set_arena(logic [ARENA_W-1:0] chunks);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= chunks;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // One random request, biased towards allocations and releases of live blocks.
  task automatic random_req();
    int pick, sz;
    logic [OFFS_W-1:0] offs;
    pick = $urandom_range(99);
    sz = $urandom_range(9);
    if (sz < 6) sz = $urandom_range(700);
    else if (sz < 8) sz = $urandom_range(4096);
    else if (sz == 8) sz = $urandom_range(65535);
    else sz = $urandom_range(131071);
    offs = OFFS_W'($urandom_range(65535));
    if (pick >= 45 && pick < 75 && known_offsets.size() > 0 && $urandom_range(4) != 0)
      offs = known_offsets[$urandom_range(known_offsets.size() - 1)];
    if (pick < 45) send_req(REQ_ALLOC, SIZE_W'(sz), TAG_W'($urandom_range(15)), offs);
    else if (pick < 75) send_req(REQ_RELEASE, SIZE_W'(sz), TAG_W'($urandom_range(15)), offs);
    else if (pick < 85) send_req(REQ_RELEASE_TAG, SIZE_W'(sz), TAG_W'($urandom_range(15)),
                                 offs);
    else send_req(REQ_QUERY, SIZE_W'(sz), TAG_W'($urandom_range(15)), offs);
  endtask

  initial begin
    logic [ARENA_W-1:0] sizes[7];
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_QUERY;
    req_ch.size_bytes = '0;
    req_ch.tag = '0;
    req_ch.block_offset = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    sizes = '{11'd64, 11'd0, 11'd2047, 11'd1, 11'd200, 11'd1024, 11'd37};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: rounding, first fit into a hole, ignored releases, tag sweeps.
    send_req(REQ_QUERY, '0, 4'd15, '0);
    send_req(REQ_ALLOC, 17'd0, 4'd3, '0);
    send_req(REQ_ALLOC, 17'd1, 4'd3, '0);
    send_req(REQ_ALLOC, 17'd64, 4'd0, '0);
    send_req(REQ_ALLOC, 17'd65, 4'd15, '0);
    send_req(REQ_ALLOC, 17'd65536, 4'd1, 16'hFFFF);
    send_req(REQ_ALLOC, 17'h1FFFF, 4'd1, '0);
    send_req(REQ_RELEASE, '0, 4'd3, 16'd64);
    send_req(REQ_RELEASE, '0, 4'd3, 16'd64);
    send_req(REQ_RELEASE, '0, 4'd3, 16'd65);
    send_req(REQ_RELEASE, '0, 4'd3, 16'hFFC0);
    send_req(REQ_RELEASE, '0, 4'd3, 16'hFFFF);
    send_req(REQ_ALLOC, 17'd10, 4'd7, '0);
    send_req(REQ_RELEASE_TAG, '0, 4'd3, '0);
    send_req(REQ_RELEASE_TAG, '0, 4'd9, '0);
    send_req(REQ_RELEASE_TAG, '0, 4'd0, '0);
    send_req(REQ_RELEASE_TAG, '0, 4'd7, '0);
    send_req(REQ_RELEASE_TAG, '0, 4'd15, '0);
    send_req(REQ_ALLOC, 17'd65536, 4'd2, '0);
    send_req(REQ_QUERY, '0, 4'd2, '0);
    send_req(REQ_RELEASE, '0, 4'd2, '0);

    // Back pressure: the result side holds off while requests keep coming.
    drain();
    no_gaps = 1'b1;
    hold_request = 1'b1;
    repeat (30) random_req();
    no_gaps = 1'b0;

    // Random phases over several arena sizes; blocks stay live across resizes.
    foreach (sizes[p]) begin
      set_arena(sizes[p]);
      repeat (52) random_req();
      if (p == 3) begin
        no_gaps = 1'b1;
        repeat (20) random_req();
        no_gaps = 1'b0;
      end
    end

    drain();
    repeat (40) @(posedge clk);
    $display("Sent %0d requests over 8 arena sizes, with long result stall and gap-free bursts.",
             sent);
    $display("Granted %0d, exhausted %0d, ignored releases %0d.", grant_count, exhaust_count,
             ignore_count);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
